// File: design/dcr_pkg.sv
package dcr_pkg;

    typedef enum logic [2:0] {
        REG_CHANNEL_ENABLE = 3'd0,
        REG_OPEN_ACTION    = 3'd1,
        REG_CLOSE_ACTION   = 3'd2,
        REG_DEBOUNCE_MS    = 3'd3,
        REG_PERIOD_MS      = 3'd4
    } t_reg_idx;

    typedef logic [1:0] t_action;

    localparam t_action ACT_NONE  = 2'd0;
    localparam t_action ACT_SEND0 = 2'd1;
    localparam t_action ACT_SEND1 = 2'd2;

    localparam int DEBOUNCE_W = 16;
    localparam int PERIOD_W   = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic send_value;
        logic last_of_run;
    } t_result;

endpackage

// File: design/debounced_contact_reporter_top.sv
// Channel    Handshake           Payload
// tick in    i_valid / o_ready   i_level_present, i_contact_level
// result     o_valid / i_ready   o_send_value, o_last_of_run
// config     APB psel/penable    paddr[4:0], pwdata[31:0], prdata[31:0]
//
// A tick transaction is processed in the cycle it is accepted, one tick per cycle while o_ready is high.
// Each tick queues zero, one or two results in a four-entry result queue.
// o_ready is high while the queue has room for two results, so output stalls
// hold off ticks only when the queue is nearly full.
// Reset is synchronous and active low; it clears all state and registers but not the result queue storage.
module debounced_contact_reporter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_level_present,
    input  logic        i_contact_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_send_value,
    output logic        o_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                            r_channel_enable;
    dcr_pkg::t_action                r_open_action;
    dcr_pkg::t_action                r_close_action;
    logic [dcr_pkg::DEBOUNCE_W-1:0]  r_debounce_ms;
    logic [dcr_pkg::PERIOD_W-1:0]    r_period_ms;

    logic                            r_raw_known,    n_raw_known;
    logic                            r_raw_level,    n_raw_level;
    logic                            r_ref_level,    n_ref_level;
    logic [dcr_pkg::DEBOUNCE_W-1:0]  r_deb_elapsed,  n_deb_elapsed;
    logic                            r_stable_known, n_stable_known;
    logic                            r_stable_level, n_stable_level;
    logic                            r_armed,        n_armed;
    logic [dcr_pkg::PERIOD_W-1:0]    r_per_elapsed,  n_per_elapsed;

    logic [dcr_pkg::DEBOUNCE_W-1:0]  deb_base;
    logic [dcr_pkg::PERIOD_W-1:0]    per_base;
    logic                            pass;
    logic                            emit_change;
    logic                            emit_period;
    logic                            emit_ok;
    dcr_pkg::t_action                act;

    dcr_pkg::t_result                r_queue [dcr_pkg::QUEUE_DEPTH];
    logic [dcr_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [dcr_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [dcr_pkg::QUEUE_CNT_W-1:0] r_count;
    logic [dcr_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic                            push0;
    logic                            push1;
    logic                            pop;
    dcr_pkg::t_result                res0;
    dcr_pkg::t_result                res1;
    logic                            in_acc;
    logic                            cfg_wr;
    dcr_pkg::t_reg_idx               cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = dcr_pkg::t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_enable <= 1'b0;
            r_open_action    <= dcr_pkg::ACT_NONE;
            r_close_action   <= dcr_pkg::ACT_NONE;
            r_debounce_ms    <= '0;
            r_period_ms      <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                dcr_pkg::REG_CHANNEL_ENABLE: r_channel_enable <= pwdata[0];
                dcr_pkg::REG_OPEN_ACTION:    r_open_action    <= pwdata[1:0];
                dcr_pkg::REG_CLOSE_ACTION:   r_close_action   <= pwdata[1:0];
                dcr_pkg::REG_DEBOUNCE_MS:    r_debounce_ms    <= pwdata[15:0];
                dcr_pkg::REG_PERIOD_MS:      r_period_ms      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            dcr_pkg::REG_CHANNEL_ENABLE: prdata = {31'd0, r_channel_enable};
            dcr_pkg::REG_OPEN_ACTION:    prdata = {30'd0, r_open_action};
            dcr_pkg::REG_CLOSE_ACTION:   prdata = {30'd0, r_close_action};
            dcr_pkg::REG_DEBOUNCE_MS:    prdata = {16'd0, r_debounce_ms};
            dcr_pkg::REG_PERIOD_MS:      prdata = r_period_ms;
            default:                     prdata = '0;
        endcase
    end

    assign in_acc = i_valid & o_ready;

    always_comb begin
        n_raw_known    = r_raw_known | i_level_present;
        n_raw_level    = i_level_present ? i_contact_level : r_raw_level;
        n_ref_level    = r_ref_level;
        deb_base       = r_deb_elapsed;
        n_stable_known = r_stable_known;
        n_stable_level = r_stable_level;
        n_armed        = r_armed;
        per_base       = r_per_elapsed;
        pass           = 1'b0;
        emit_change    = 1'b0;
        emit_period    = 1'b0;

        if (n_raw_known) begin
            if (r_debounce_ms != '0) begin
                if (n_raw_level != r_ref_level) begin
                    n_ref_level = n_raw_level;
                    deb_base    = '0;
                end
                pass = (deb_base >= r_debounce_ms);
            end else begin
                pass = 1'b1;
            end
            if (pass && (!r_stable_known || n_raw_level != r_stable_level)) begin
                n_stable_known = 1'b1;
                n_stable_level = n_raw_level;
                emit_change    = 1'b1;
            end
        end

        if (n_stable_known && r_period_ms != '0) begin
            if (!r_armed) begin
                n_armed  = 1'b1;
                per_base = '0;
            end else if (r_per_elapsed >= r_period_ms) begin
                per_base    = '0;
                emit_period = 1'b1;
            end
        end

        n_deb_elapsed = (deb_base != '1) ? deb_base + 1'b1 : deb_base;
        n_per_elapsed = (n_armed && per_base != '1) ? per_base + 1'b1 : per_base;

        act     = n_stable_level ? r_close_action : r_open_action;
        emit_ok = (act == dcr_pkg::ACT_SEND0) || (act == dcr_pkg::ACT_SEND1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_known    <= 1'b0;
            r_raw_level    <= 1'b0;
            r_ref_level    <= 1'b0;
            r_deb_elapsed  <= '0;
            r_stable_known <= 1'b0;
            r_stable_level <= 1'b0;
            r_armed        <= 1'b0;
            r_per_elapsed  <= '0;
        end else if (in_acc && r_channel_enable) begin
            r_raw_known    <= n_raw_known;
            r_raw_level    <= n_raw_level;
            r_ref_level    <= n_ref_level;
            r_deb_elapsed  <= n_deb_elapsed;
            r_stable_known <= n_stable_known;
            r_stable_level <= n_stable_level;
            r_armed        <= n_armed;
            r_per_elapsed  <= n_per_elapsed;
        end
    end

    // Both results of one tick carry the same value; only the final one is marked last.
    assign push0 = in_acc && r_channel_enable && emit_ok && (emit_change || emit_period);
    assign push1 = in_acc && r_channel_enable && emit_ok && emit_change && emit_period;
    assign res0.send_value  = (act == dcr_pkg::ACT_SEND1);
    assign res0.last_of_run = ~push1;
    assign res1.send_value  = (act == dcr_pkg::ACT_SEND1);
    assign res1.last_of_run = 1'b1;
    assign wr_ptr_next = r_wr_ptr + 1'b1;

    assign o_valid = (r_count != '0);
    assign o_ready = (r_count <= dcr_pkg::QUEUE_CNT_W'(dcr_pkg::QUEUE_DEPTH - 2));
    assign pop     = o_valid & i_ready;
    assign o_send_value  = r_queue[r_rd_ptr].send_value;
    assign o_last_of_run = r_queue[r_rd_ptr].last_of_run;

    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (push1) begin
            r_queue[wr_ptr_next] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + dcr_pkg::QUEUE_PTR_W'(push0) + dcr_pkg::QUEUE_PTR_W'(push1);
            r_rd_ptr <= r_rd_ptr + dcr_pkg::QUEUE_PTR_W'(pop);
            r_count  <= r_count + dcr_pkg::QUEUE_CNT_W'(push0) + dcr_pkg::QUEUE_CNT_W'(push1)
                        - dcr_pkg::QUEUE_CNT_W'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dcr_pkg::QUEUE_CNT_W'(dcr_pkg::QUEUE_DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_partner_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> (r_count >= dcr_pkg::QUEUE_CNT_W'(2)))
        else $error("A non-final result has no final result queued behind it.");

    a_disabled_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_channel_enable) |=> (r_count <= $past(r_count)))
        else $error("A transaction on a disabled channel produced a result.");

    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_per_elapsed == '0))
        else $error("Periodic timer counted before it was armed.");
`endif

endmodule
